>>> hdl/bmf_pkg.sv
// Shared types, constants and helper functions of the binary morphology filter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bmf_pkg;

    // Frame and window limits
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MAX_RADIUS  = 7;
    localparam int WIN         = 2 * MAX_RADIUS + 1;
    localparam int HALF        = MAX_RADIUS;
    localparam int ROW_TAGS    = 16;
    localparam int STRIP_COLS  = MAX_RADIUS;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [23:0] WHITE_RGB = 24'hFFFFFF;

    typedef enum logic [1:0] {
        MODE_DILATE = 2'd0,
        MODE_ERODE  = 2'd1,
        MODE_OPEN   = 2'd2,
        MODE_CLOSE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_OP_MODE = 2'd0,
        CFG_RADIUS  = 2'd1,
        CFG_WIDTH   = 2'd2,
        CFG_HEIGHT  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        req_type;
        logic [23:0] pixel_rgb;
    } t_in;

    typedef struct packed {
        logic        out_white;
        logic [9:0]  out_col;
        logic [11:0] out_row;
        logic        frame_last;
    } t_out;

    // Effective (clamped) configuration
    typedef struct packed {
        t_mode       mode;
        logic [2:0]  radius;
        logic [10:0] width;
        logic [12:0] height;
    } t_cfg;

    // Raster position plus running row tag (row count modulo ROW_TAGS)
    typedef struct packed {
        logic [9:0]  col;
        logic [11:0] row;
        logic [3:0]  tag;
    } t_pos;

    // Work of one stage for one beat
    typedef struct packed {
        logic        push;
        logic [9:0]  push_col;
        logic [3:0]  push_tag;
        logic        emit;
        t_pos        epos;
    } t_stg_cmd;

    typedef struct packed {
        logic     px;
        logic     res1;
        logic     use2;
        logic     fin_emit;
        logic     fin_last;
        t_pos     fin_pos;
        t_stg_cmd s1;
        t_stg_cmd s2;
    } t_item;

    // Number of pixels past an output position that must be in before it can go
    function automatic logic [13:0] fn_thresh(input t_cfg c, input t_pos p);
        logic [12:0] rrem;
        logic [10:0] crem;
        logic [2:0]  mr;
        logic [2:0]  mc;
        rrem = c.height - 13'd1 - {1'b0, p.row};
        crem = c.width - 11'd1 - {1'b0, p.col};
        mr = (rrem < {10'd0, c.radius}) ? rrem[2:0] : c.radius;
        mc = (crem < {8'd0, c.radius}) ? crem[2:0] : c.radius;
        return ({11'd0, mr} * {3'd0, c.width}) + {11'd0, mc};
    endfunction

    function automatic logic fn_is_last(input t_cfg c, input t_pos p);
        return ({1'b0, p.col} == c.width - 11'd1) && ({1'b0, p.row} == c.height - 13'd1);
    endfunction

    function automatic t_pos fn_next_pos(input t_cfg c, input t_pos p);
        t_pos n;
        n = p;
        if ({1'b0, p.col} == c.width - 11'd1) begin
            n.col = '0;
            n.tag = p.tag + 4'd1;
            if ({1'b0, p.row} == c.height - 13'd1) begin
                n.row = '0;
            end else begin
                n.row = p.row + 12'd1;
            end
        end else begin
            n.col = p.col + 10'd1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

>>> hdl/bmf_queue.sv
// Short queue of classified beats between the front and the back.
// Depends on bmf_pkg.
`default_nettype none

module bmf_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  bmf_pkg::t_item   i_item,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output bmf_pkg::t_item   o_item
);

    localparam int PW = $clog2(bmf_pkg::QUEUE_DEPTH);

    bmf_pkg::t_item r_mem [bmf_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [PW:0]    r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(bmf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    // Store beats
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/bmf_front.sv
// Front of the filter: configuration registers, pixel/output counters of both
// stages, and classification of each beat into stage work. Depends on bmf_pkg.
`default_nettype none

module bmf_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [1:0]        i_cfg_idx,
    input  wire  [12:0]       i_cfg_data,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  bmf_pkg::t_in      i_in_data,
    input  wire               i_q_full,
    output logic              o_push,
    output bmf_pkg::t_item    o_item,
    output bmf_pkg::t_cfg     o_cfg
);

    bmf_pkg::t_mode r_op_mode;
    logic [2:0]     r_radius;
    logic [10:0]    r_width;
    logic [12:0]    r_height;

    // Pixels in but not yet out, per stage
    logic [13:0]    r_d1;
    logic [13:0]    r_d2;
    bmf_pkg::t_pos  r_ipos;
    bmf_pkg::t_pos  r_opos1;
    bmf_pkg::t_pos  r_opos2;

    logic [13:0]    n_d1;
    logic [13:0]    n_d2;
    logic [13:0]    d1_in;
    logic [13:0]    d2_in;
    logic           has_px;
    logic           en2;
    logic           emit1;
    logic           emit2;
    logic           push2;
    bmf_pkg::t_cfg  cfg;
    bmf_pkg::t_item item;

    // Clamp configuration to the supported frame
    always_comb begin
        cfg.mode   = r_op_mode;
        cfg.radius = r_radius;
        if (r_width == '0) begin
            cfg.width = 11'd1;
        end else if (r_width > 11'(bmf_pkg::MAX_WIDTH)) begin
            cfg.width = 11'(bmf_pkg::MAX_WIDTH);
        end else begin
            cfg.width = r_width;
        end
        if (r_height == '0) begin
            cfg.height = 13'd1;
        end else if (r_height > 13'(bmf_pkg::MAX_HEIGHT)) begin
            cfg.height = 13'(bmf_pkg::MAX_HEIGHT);
        end else begin
            cfg.height = r_height;
        end
    end

    assign o_cfg      = cfg;
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Classify the beat: what each stage takes in and gives out
    always_comb begin
        has_px = !i_in_data.req_type;
        en2    = (r_op_mode == bmf_pkg::MODE_OPEN) || (r_op_mode == bmf_pkg::MODE_CLOSE);
        d1_in  = r_d1 + {13'd0, has_px};
        emit1  = d1_in > bmf_pkg::fn_thresh(cfg, r_opos1);
        n_d1   = d1_in - {13'd0, emit1};
        push2  = en2 && emit1;
        d2_in  = r_d2 + {13'd0, push2};
        emit2  = en2 && (d2_in > bmf_pkg::fn_thresh(cfg, r_opos2));
        n_d2   = d2_in - {13'd0, emit2};

        item.px          = (i_in_data.pixel_rgb == bmf_pkg::WHITE_RGB);
        item.res1        = 1'b0;
        item.use2        = en2;
        item.s1.push     = has_px;
        item.s1.push_col = r_ipos.col;
        item.s1.push_tag = r_ipos.tag;
        item.s1.emit     = emit1;
        item.s1.epos     = r_opos1;
        item.s2.push     = push2;
        item.s2.push_col = r_opos1.col;
        item.s2.push_tag = r_opos1.tag;
        item.s2.emit     = emit2;
        item.s2.epos     = r_opos2;
        if (en2) begin
            item.fin_emit = emit2;
            item.fin_pos  = r_opos2;
        end else begin
            item.fin_emit = emit1;
            item.fin_pos  = r_opos1;
        end
        item.fin_last = bmf_pkg::fn_is_last(cfg, item.fin_pos);
    end

    assign o_item = item;

    // Configuration writes; any write empties both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode <= bmf_pkg::MODE_DILATE;
            r_radius  <= 3'd1;
            r_width   <= 11'd640;
            r_height  <= 13'd480;
        end else if (i_cfg_we) begin
            case (bmf_pkg::t_cfg_idx'(i_cfg_idx))
                bmf_pkg::CFG_OP_MODE: r_op_mode <= bmf_pkg::t_mode'(i_cfg_data[1:0]);
                bmf_pkg::CFG_RADIUS:  r_radius  <= i_cfg_data[2:0];
                bmf_pkg::CFG_WIDTH:   r_width   <= i_cfg_data[10:0];
                bmf_pkg::CFG_HEIGHT:  r_height  <= i_cfg_data;
                default:              r_radius  <= r_radius;
            endcase
        end
    end

    // Advance counters on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_d1    <= '0;
            r_d2    <= '0;
            r_ipos  <= '0;
            r_opos1 <= '0;
            r_opos2 <= '0;
        end else if (o_push) begin
            r_d1 <= n_d1;
            r_d2 <= n_d2;
            if (has_px) begin
                r_ipos <= bmf_pkg::fn_next_pos(cfg, r_ipos);
            end
            if (emit1) begin
                r_opos1 <= bmf_pkg::fn_next_pos(cfg, r_opos1);
            end
            if (emit2) begin
                r_opos2 <= bmf_pkg::fn_next_pos(cfg, r_opos2);
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/bmf_stage.sv
// One morphology stage: column line store, left-edge strip, sliding 15x16
// window and the masked OR/AND reduction. Depends on bmf_pkg.
`default_nettype none

module bmf_stage (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_adv,
    input  wire                i_valid,
    input  bmf_pkg::t_stg_cmd  i_cmd,
    input  wire                i_bit,
    input  bmf_pkg::t_cfg      i_cfg,
    input  wire                i_erode,
    output logic               o_result
);

    localparam int W  = bmf_pkg::WIN;
    localparam int H  = bmf_pkg::HALF;
    localparam int TG = bmf_pkg::ROW_TAGS;
    localparam int SC = bmf_pkg::STRIP_COLS;

    // One word per column, one bit per row tag
    logic [TG-1:0] r_mem   [bmf_pkg::MAX_WIDTH];
    logic [TG-1:0] r_strip [SC];
    logic [TG-1:0] r_left  [SC];
    logic [TG-1:0] r_win   [W];
    logic [TG-1:0] n_win   [W];
    logic [TG-1:0] n_left  [SC];
    logic [TG-1:0] r_rd;
    logic          r_byp;
    logic [3:0]    r_byp_tag;
    logic          r_byp_bit;
    logic          r_vb;
    bmf_pkg::t_stg_cmd r_cmd_b;
    logic          r_res;

    logic [10:0]   rcol_full;
    logic [9:0]    rcol;
    logic [TG-1:0] col_word;
    logic          row_start;
    logic [W-1:0]  rv;
    logic [W-1:0]  cv;
    logic [3:0]    rtag [W];
    logic          any_w;
    logic          all_w;
    logic          res;

    assign rcol_full = {1'b0, i_cmd.epos.col} + {8'd0, i_cfg.radius};
    assign rcol      = rcol_full[9:0];

    // Strip view with this beat's pixel applied
    always_comb begin
        for (int k = 0; k < SC; k++) begin
            n_left[k] = r_strip[k];
            if (i_cmd.push && i_cmd.push_col == 10'(k)) begin
                n_left[k][i_cmd.push_tag] = i_bit;
            end
        end
    end

    // Write the pixel, read the column entering the window
    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            if (i_cmd.push) begin
                r_mem[i_cmd.push_col][i_cmd.push_tag] <= i_bit;
            end
            r_rd      <= r_mem[rcol];
            r_byp     <= i_cmd.push && (i_cmd.push_col == rcol);
            r_byp_tag <= i_cmd.push_tag;
            r_byp_bit <= i_bit;
            r_left    <= n_left;
            r_cmd_b   <= i_cmd;
        end
    end

    // Keep the first columns of each row in flops for row starts
    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid && i_cmd.push && i_cmd.push_col < 10'(SC)) begin
            r_strip[i_cmd.push_col[2:0]][i_cmd.push_tag] <= i_bit;
        end
    end

    // Build next window and reduce it
    always_comb begin
        logic b;
        col_word = r_rd;
        if (r_byp) begin
            col_word[r_byp_tag] = r_byp_bit;
        end
        row_start = (r_cmd_b.epos.col == '0);
        for (int m = 0; m < W; m++) begin
            n_win[m] = '0;
        end
        if (row_start) begin
            for (int k = 0; k < SC; k++) begin
                if (k < int'(i_cfg.radius)) begin
                    n_win[H + k] = r_left[k];
                end
            end
        end else begin
            for (int m = 0; m < W - 1; m++) begin
                n_win[m] = r_win[m + 1];
            end
        end
        n_win[4'(H) + {1'b0, i_cfg.radius}] = col_word;

        for (int i = 0; i < W; i++) begin
            rtag[i] = r_cmd_b.epos.tag + 4'(i + TG - H);
            rv[i] = (i + int'(i_cfg.radius) >= H) && (i <= H + int'(i_cfg.radius))
                && ({2'd0, r_cmd_b.epos.row} + 14'(i) >= 14'(H))
                && ({2'd0, r_cmd_b.epos.row} + 14'(i) <= {1'b0, i_cfg.height} + 14'(H - 1));
            cv[i] = (i + int'(i_cfg.radius) >= H) && (i <= H + int'(i_cfg.radius))
                && ({2'd0, r_cmd_b.epos.col} + 12'(i) >= 12'(H))
                && ({2'd0, r_cmd_b.epos.col} + 12'(i) <= {1'b0, i_cfg.width} + 12'(H - 1));
        end

        any_w = 1'b0;
        all_w = 1'b1;
        for (int i = 0; i < W; i++) begin
            for (int j = 0; j < W; j++) begin
                b = n_win[j][rtag[i]];
                if (rv[i] && cv[j] && !(i == H && j == H)) begin
                    any_w = any_w | b;
                    all_w = all_w & b;
                end
            end
        end
        res = i_erode ? all_w : any_w;
    end

    // Track the beat in the window step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (i_adv) begin
            r_vb <= i_valid;
        end
    end

    // Slide the window and hold the result
    always_ff @(posedge i_clk) begin
        if (i_adv && r_vb && r_cmd_b.emit) begin
            r_win <= n_win;
            r_res <= res;
        end
    end

    assign o_result = r_res;

endmodule

`default_nettype wire

>>> hdl/bmf_back.sv
// Back of the filter: pops classified beats, runs them through both stages in
// lockstep and holds the result beat. Depends on bmf_pkg and bmf_stage.
`default_nettype none

module bmf_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  bmf_pkg::t_cfg     i_cfg,
    input  wire               i_q_valid,
    input  bmf_pkg::t_item    i_q_item,
    output logic              o_pop,
    output logic              o_out_valid,
    output bmf_pkg::t_out     o_out_data,
    input  wire               i_out_ready
);

    logic           adv;
    logic           r_v1;
    logic           r_v2;
    logic           r_v3;
    logic           r_v4;
    bmf_pkg::t_item r_it1;
    bmf_pkg::t_item r_it2;
    bmf_pkg::t_item r_it3;
    bmf_pkg::t_item r_it4;
    bmf_pkg::t_item n_it3;
    logic           res1;
    logic           res2;
    logic           erode1;
    logic           erode2;

    assign erode1 = (i_cfg.mode == bmf_pkg::MODE_ERODE) || (i_cfg.mode == bmf_pkg::MODE_OPEN);
    assign erode2 = (i_cfg.mode == bmf_pkg::MODE_CLOSE);

    // Whole pipe moves unless a result beat is stuck
    assign o_out_valid = r_v4 && r_it4.fin_emit;
    assign adv         = !o_out_valid || i_out_ready;
    assign o_pop       = adv && i_q_valid;

    bmf_stage u_stage1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (i_q_valid),
        .i_cmd    (i_q_item.s1),
        .i_bit    (i_q_item.px),
        .i_cfg    (i_cfg),
        .i_erode  (erode1),
        .o_result (res1)
    );

    bmf_stage u_stage2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (r_v2),
        .i_cmd    (r_it2.s2),
        .i_bit    (res1),
        .i_cfg    (i_cfg),
        .i_erode  (erode2),
        .o_result (res2)
    );

    // Carry beats alongside the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_q_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Attach the first stage result to its beat
    always_comb begin
        n_it3      = r_it2;
        n_it3.res1 = res1;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_it1 <= i_q_item;
            r_it2 <= r_it1;
            r_it3 <= n_it3;
            r_it4 <= r_it3;
        end
    end

    // Result beat
    always_comb begin
        o_out_data.out_white  = r_it4.use2 ? res2 : r_it4.res1;
        o_out_data.out_col    = r_it4.fin_pos.col;
        o_out_data.out_row    = r_it4.fin_pos.row;
        o_out_data.frame_last = r_it4.fin_last;
    end

endmodule

`default_nettype wire

>>> hdl/binary_morphology_filter_unit.sv
// Top level of the binary morphology filter: front, beat queue and back.
// Depends on bmf_pkg, bmf_front, bmf_queue and bmf_back.
`default_nettype none

// Streaming binary dilate/erode/open/close on a square window of radius 0..7
// over frames up to 1024x4096, pixels in raster order. A pixel counts as set
// only when exactly white. The block takes one beat per clock while its queue
// is not full and gives at most one result beat per input beat; each stage has
// a column store with one write and one read per clock, so throughput is one
// beat per cycle whenever the output side is ready. A taken beat waits in the
// queue, then passes the column-read and window registers of each stage.
// Results lag pixels by up to radius rows plus radius pixels per stage; send
// flush beats at frame end to drain them. Write configuration only while
// idle; every write starts a fresh frame.
module binary_morphology_filter_unit (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [1:0]        i_cfg_idx,
    input  wire  [12:0]       i_cfg_data,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  bmf_pkg::t_in      i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output bmf_pkg::t_out     o_out_data
);

    logic           push;
    logic           q_full;
    logic           q_valid;
    logic           pop;
    bmf_pkg::t_item f_item;
    bmf_pkg::t_item q_item;
    bmf_pkg::t_cfg  cfg;

    bmf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_item     (f_item),
        .o_cfg      (cfg)
    );

    bmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    bmf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

endmodule

`default_nettype wire

>>> dv/tb_binary_morphology_filter_unit.sv
// Self-checking testbench of binary_morphology_filter_unit: random and directed
// frames in every mode, checked beat by beat against a built-in predictor.
// Depends on bmf_pkg and the binary_morphology_filter_unit RTL.
`timescale 1ns / 100ps

// Predicts the filtered pixel stream and checks the result beats
class morph_scoreboard;
    localparam int HIST = 2 * (bmf_pkg::MAX_RADIUS * bmf_pkg::MAX_WIDTH
                               + bmf_pkg::MAX_RADIUS) + 4;

    bit [1:0]  mode_r;
    bit [2:0]  radius_r;
    bit [10:0] width_r;
    bit [12:0] height_r;

    bit     hist [2][HIST];
    longint in_cnt [2];
    longint out_cnt [2];

    bmf_pkg::t_out want_q [$];
    int     errors;
    int     results;

    function new();
        mode_r   = bmf_pkg::MODE_DILATE;
        radius_r = 3'd1;
        width_r  = 11'd640;
        height_r = 13'd480;
        errors   = 0;
        results  = 0;
        clear_lines();
    endfunction

    function void clear_lines();
        for (int s = 0; s < 2; s++) begin
            in_cnt[s]  = 0;
            out_cnt[s] = 0;
            for (int i = 0; i < HIST; i++) hist[s][i] = 1'b0;
        end
    endfunction

    function int eff_w();
        if (width_r == 0) return 1;
        return (width_r > bmf_pkg::MAX_WIDTH) ? bmf_pkg::MAX_WIDTH : int'(width_r);
    endfunction

    function int eff_h();
        if (height_r == 0) return 1;
        return (height_r > bmf_pkg::MAX_HEIGHT) ? bmf_pkg::MAX_HEIGHT : int'(height_r);
    endfunction

    // Store a register and restart both stages
    function void write_reg(bmf_pkg::t_cfg_idx idx, bit [12:0] val);
        case (idx)
            bmf_pkg::CFG_OP_MODE: mode_r   = val[1:0];
            bmf_pkg::CFG_RADIUS:  radius_r = val[2:0];
            bmf_pkg::CFG_WIDTH:   width_r  = val[10:0];
            bmf_pkg::CFG_HEIGHT:  height_r = val[12:0];
            default:              ;
        endcase
        clear_lines();
    endfunction

    // Advance one stage: take its pixel, then emit the next output if its window is in
    function bit stage_step(int s, bit erode, bit has_px, bit px,
                            output bit res, output longint pos);
        longint w, h, r, n, q, fb, row, col, nr, nc, rr, cc, idx;
        bit any_w, all_w;
        w = eff_w();
        h = eff_h();
        r = radius_r;
        n = w * h;
        any_w = 1'b0;
        all_w = 1'b1;
        res = 1'b0;
        pos = 0;
        if (has_px) begin
            hist[s][in_cnt[s] % HIST] = px;
            in_cnt[s]++;
        end
        q   = out_cnt[s] % n;
        fb  = out_cnt[s] - q;
        row = q / w;
        col = q % w;
        nr  = (row + r > h - 1) ? h - 1 : row + r;
        nc  = (col + r > w - 1) ? w - 1 : col + r;
        if (in_cnt[s] <= fb + nr * w + nc) return 1'b0;
        for (longint dr = -r; dr <= r; dr++) begin
            rr = row + dr;
            if (rr < 0 || rr >= h) continue;
            for (longint dc = -r; dc <= r; dc++) begin
                cc = col + dc;
                if (cc < 0 || cc >= w) continue;
                if (dr == 0 && dc == 0) continue;
                idx = fb + rr * w + cc;
                any_w = any_w | hist[s][idx % HIST];
                all_w = all_w & hist[s][idx % HIST];
            end
        end
        res = erode ? all_w : any_w;
        pos = q;
        out_cnt[s]++;
        return 1'b1;
    endfunction

    // Note an accepted input beat; returns 1 when either stage emitted
    function bit note_input(bmf_pkg::t_in d);
        bit b1, b2, got1, got, bitv, erode1;
        longint p1, p2, posv, w;
        bmf_pkg::t_out o;
        erode1 = (mode_r == bmf_pkg::MODE_ERODE) || (mode_r == bmf_pkg::MODE_OPEN);
        got1 = stage_step(0, erode1, !d.req_type, d.pixel_rgb == bmf_pkg::WHITE_RGB,
                          b1, p1);
        got  = got1;
        bitv = b1;
        posv = p1;
        if (mode_r == bmf_pkg::MODE_OPEN || mode_r == bmf_pkg::MODE_CLOSE) begin
            got  = stage_step(1, mode_r == bmf_pkg::MODE_CLOSE, got1, b1, b2, p2);
            bitv = b2;
            posv = p2;
        end
        if (got) begin
            w = eff_w();
            o.out_white  = bitv;
            o.out_col    = 10'(posv % w);
            o.out_row    = 12'(posv / w);
            o.frame_last = (posv == w * eff_h() - 1);
            want_q.push_back(o);
        end
        return got1 | got;
    endfunction

    // Compare a result beat with the oldest prediction
    function void check(bmf_pkg::t_out a);
        bmf_pkg::t_out e;
        results++;
        if (want_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: unexpected result white=%0d col=%0d row=%0d last=%0d",
                         a.out_white, a.out_col, a.out_row, a.frame_last);
            return;
        end
        e = want_q.pop_front();
        if (a.out_white !== e.out_white || a.out_col !== e.out_col ||
            a.out_row !== e.out_row || a.frame_last !== e.frame_last) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: exp white=%0d col=%0d row=%0d last=%0d, got %0d %0d %0d %0d",
                         e.out_white, e.out_col, e.out_row, e.frame_last,
                         a.out_white, a.out_col, a.out_row, a.frame_last);
        end
    endfunction
endclass

module tb_binary_morphology_filter_unit;
    localparam int STALL_LIMIT = 3000;
    localparam int ITEM_GOAL   = 1850;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_idx;
    logic [12:0]   i_cfg_data;
    logic          i_in_valid;
    logic          o_in_ready;
    bmf_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_ready;
    bmf_pkg::t_out o_out_data;

    morph_scoreboard sb;
    bit  no_idle;
    int  beats_sent;
    int  stall_cnt;
    int  frames_run;

    binary_morphology_filter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    // Send one input beat; returns whether the predictor saw any stage emit
    task automatic send_beat(input bmf_pkg::t_in d, output bit emitted);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do @(posedge i_clk); while (!o_in_ready);
        emitted = sb.note_input(d);
        beats_sent++;
    endtask

    task automatic send_pixel(input logic [23:0] rgb);
        bmf_pkg::t_in d;
        bit  em;
        d.req_type  = 1'b0;
        d.pixel_rgb = rgb;
        send_beat(d, em);
    endtask

    // Flush until a flush beat makes no stage emit
    task automatic drain();
        bmf_pkg::t_in d;
        bit  em;
        d.req_type = 1'b1;
        do begin
            d.pixel_rgb = 24'($urandom());
            send_beat(d, em);
        end while (em);
    endtask

    // Hold until every result is in and the pipeline is quiet
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input bmf_pkg::t_cfg_idx idx, input logic [12:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic configure(input bmf_pkg::t_mode m, input int r, input int w,
                             input int h);
        wait_idle();
        write_reg(bmf_pkg::CFG_OP_MODE, 13'(m));
        write_reg(bmf_pkg::CFG_RADIUS, 13'(r));
        write_reg(bmf_pkg::CFG_WIDTH, 13'(w));
        write_reg(bmf_pkg::CFG_HEIGHT, 13'(h));
    endtask

    function automatic logic [23:0] rand_rgb(input int white_pct);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < white_pct) return bmf_pkg::WHITE_RGB;
        if (sel < white_pct + 10)
            return bmf_pkg::WHITE_RGB ^ (24'd1 << $urandom_range(0, 23));
        return 24'($urandom());
    endfunction

    // Run frames of the current setup; the last one is always drained
    task automatic run_frames(input int nframes, input int npix);
        int wpct;
        for (int f = 0; f < nframes; f++) begin
            wpct = $urandom_range(0, 3) * 30;
            for (int i = 0; i < npix; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    bmf_pkg::t_in d;
                    bit  em;
                    d.req_type  = 1'b1;
                    d.pixel_rgb = 24'($urandom());
                    send_beat(d, em);
                end
                send_pixel(rand_rgb(wpct));
            end
            if (f == nframes - 1 || $urandom_range(0, 1)) drain();
            frames_run++;
        end
    endtask

    // Accept result beats with random stalls
    initial begin
        int gap;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Check each accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check(o_out_data);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
            $display("** binary_morphology_filter_unit: FAILED **");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        bmf_pkg::t_mode m;
        sb         = new();
        no_idle    = 1'b0;
        beats_sent = 0;
        frames_run = 0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = bmf_pkg::CFG_OP_MODE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, mid-frame flush, radius zero in every mode
        configure(bmf_pkg::MODE_DILATE, 0, 3, 2);
        send_pixel(bmf_pkg::WHITE_RGB);
        send_pixel(24'hFFFFFE);
        begin
            bmf_pkg::t_in d;
            bit  em;
            d.req_type  = 1'b1;
            d.pixel_rgb = bmf_pkg::WHITE_RGB;
            send_beat(d, em);
        end
        send_pixel(24'h000000);
        send_pixel(24'h7FFFFF);
        send_pixel(bmf_pkg::WHITE_RGB);
        send_pixel(24'hAAAAAA);
        drain();
        for (int k = 0; k < 4; k++) begin
            m = bmf_pkg::t_mode'(k);
            configure(m, 0, 2, 2);
            run_frames(1, 4);
            configure(m, 7, 1, 1);
            run_frames(1, 1);
        end

        // Saturated sizes: width and height beyond range, zero width and height,
        // max radius; partial frames, then two full 16x9 frames
        configure(bmf_pkg::MODE_DILATE, 7, 2047, 0);
        run_frames(1, 40);
        configure(bmf_pkg::MODE_CLOSE, 7, 0, 8191);
        run_frames(1, 40);
        configure(bmf_pkg::MODE_OPEN, 7, 16, 9);
        run_frames(2, 144);

        // Random setups on small frames, with idle-free stretches
        while (beats_sent < ITEM_GOAL) begin
            m = bmf_pkg::t_mode'($urandom_range(0, 3));
            configure(m, $urandom_range(0, 7), $urandom_range(1, 20), $urandom_range(1, 10));
            no_idle = ($urandom_range(0, 3) == 0);
            run_frames($urandom_range(1, 3), int'(sb.eff_w() * sb.eff_h()));
        end
        no_idle = 1'b0;

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (sb.want_q.size() != 0) begin
            sb.errors++;
            $display("ERROR: %0d results never arrived", sb.want_q.size());
        end
        $display("Ran %0d input beats over %0d frames in all four modes, radius 0 to 7.",
                 beats_sent, frames_run);
        $display("Checked %0d result beats, %0d mismatches.", sb.results, sb.errors);
        if (sb.errors == 0) begin
            $display("** binary_morphology_filter_unit: PASSED **");
        end else begin
            $display("** binary_morphology_filter_unit: FAILED **");
        end
        $finish;
    end
endmodule
